// ===== rtl/core/buddy_block_allocator_defines.svh =====
// Assertion macros shared by the buddy block allocator checkers.
// Stands alone; included by the checker file.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BBA_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buddy allocator check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high.
`define BBA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buddy allocator check failed: next-cycle rule");

`endif

// ===== rtl/core/bba_pkg.sv =====
// Package of the buddy block allocator: widths, defaults, FSM and command types.
// No dependencies.
package bba_pkg;

   localparam int unsigned MAX_ORDER_DEF = 20;
   localparam int unsigned MIN_ORDER_DEF = 4;

   localparam int unsigned SIZE_W      = 21;
   localparam int unsigned ADDR_OUT_W  = 20;
   localparam int unsigned ORDER_OUT_W = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIZE,
      ST_SCAN,
      ST_LINK,
      ST_SPLIT,
      ST_GRANT,
      ST_REFUSE
   } bba_state_type;

   typedef struct packed {
      logic capture;
      logic init_scan;
      logic scan_step;
      logic pop;
      logic unlink;
      logic descend;
      logic split;
      logic load_grant;
      logic load_refuse;
   } bba_cmd_type;

   typedef struct packed {
      logic oversize;
      logic head_valid;
      logic at_top;
      logic at_want;
      logic out_free;
   } bba_status_type;

endpackage

// ===== rtl/core/bba_if.sv =====
// Request and response channel interfaces of the buddy block allocator.
// Depends on bba_pkg.
interface bba_req_if;
   import bba_pkg::*;

   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] request_size;

   modport source (output valid, output request_size, input ready);
   modport sink   (input valid, input request_size, output ready);
endinterface

interface bba_rsp_if;
   import bba_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   granted;
   logic [ADDR_OUT_W-1:0]  block_address;
   logic [ORDER_OUT_W-1:0] block_order;

   modport source (output valid, output granted, output block_address,
                   output block_order, input ready);
   modport sink   (input valid, input granted, input block_address,
                   input block_order, output ready);
endinterface

// ===== rtl/core/bba_datapath.sv =====
// Datapath of the buddy block allocator: free list heads, link memory,
// order computation and the response register. Depends on bba_pkg.
module bba_datapath #(
   parameter int unsigned MAX_ORDER = bba_pkg::MAX_ORDER_DEF,
   parameter int unsigned MIN_ORDER = bba_pkg::MIN_ORDER_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bba_pkg::bba_cmd_type                 cmd,
   output bba_pkg::bba_status_type              status,
   input  logic [bba_pkg::SIZE_W-1:0]           req_size,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic                                 rsp_granted,
   output logic [bba_pkg::ADDR_OUT_W-1:0]       rsp_addr,
   output logic [bba_pkg::ORDER_OUT_W-1:0]      rsp_order
);
   import bba_pkg::*;

   localparam int unsigned EFF_MIN = (MIN_ORDER < MAX_ORDER) ? MIN_ORDER : MAX_ORDER;
   localparam int unsigned ADDR_W  = MAX_ORDER;
   localparam int unsigned ORD_W   = $clog2(MAX_ORDER + 1);
   localparam int unsigned SLOT_W  = (MAX_ORDER > EFF_MIN) ? (MAX_ORDER - EFF_MIN) : 1;
   localparam longint unsigned DEPTH = 64'd1 << SLOT_W;
   localparam int unsigned CMP_W   = (MAX_ORDER + 1 > SIZE_W) ? (MAX_ORDER + 1) : SIZE_W;
   localparam int unsigned AXW     = (ADDR_W > ADDR_OUT_W) ? ADDR_W : ADDR_OUT_W;
   localparam int unsigned OXW     = (ORD_W > ORDER_OUT_W) ? ORD_W : ORDER_OUT_W;
   localparam logic [ORD_W-1:0] TOP_ORD = ORD_W'(MAX_ORDER);
   localparam logic [ORD_W-1:0] MIN_ORD = ORD_W'(EFF_MIN);

   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [ORD_W-1:0]   want_ff, want_in;
   logic [ORD_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W:0]    link_rd_ff;

   logic               head_valid_ff [MAX_ORDER+1];
   logic [ADDR_W-1:0]  head_addr_ff  [MAX_ORDER+1];
   logic [ADDR_W:0]    link_mem      [DEPTH];

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_granted_ff;
   logic [AXW-1:0]     rsp_addr_ff;
   logic [OXW-1:0]     rsp_order_ff;

   logic [CMP_W-1:0]   size_ext;
   logic [ORD_W-1:0]   want_calc;
   logic               head_cur_valid;
   logic [ADDR_W-1:0]  head_cur_addr;
   logic [ADDR_W-1:0]  upper_addr;
   logic               head_we;
   logic               head_wvalid;
   logic [ADDR_W-1:0]  head_waddr;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] s;
      s = a >> EFF_MIN;
      return s[SLOT_W-1:0];
   endfunction

   // Wanted order: one above the highest threshold 2^k that lies below the size,
   // or the minimum order when no threshold does. The thresholds pass in a run
   // from the bottom, so the last one that passes decides.
   always_comb begin
      size_ext  = CMP_W'(size_ff);
      want_calc = MIN_ORD;
      for (int k = 0; k < MAX_ORDER; k++) begin
         if (k >= EFF_MIN && (CMP_W'(1) << k) < size_ext) begin
            want_calc = ORD_W'(k + 1);
         end
      end
   end

   assign head_cur_valid = head_valid_ff[idx_ff];
   assign head_cur_addr  = head_addr_ff[idx_ff];
   assign upper_addr     = addr_ff | (ADDR_W'(1) << idx_ff);

   always_comb begin
      size_in = cmd.capture   ? req_size      : size_ff;
      want_in = cmd.init_scan ? want_calc     : want_ff;
      addr_in = cmd.pop       ? head_cur_addr : addr_ff;
      if (cmd.init_scan) begin
         idx_in = want_calc;
      end else if (cmd.scan_step) begin
         idx_in = idx_ff + ORD_W'(1);
      end else if (cmd.descend || cmd.split) begin
         idx_in = idx_ff - ORD_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   // The whole region has no successor, so popping the top list empties it.
   always_comb begin
      head_we     = cmd.unlink || cmd.split;
      head_wvalid = 1'b1;
      head_waddr  = upper_addr;
      if (cmd.unlink) begin
         if (idx_ff == TOP_ORD) begin
            head_wvalid = 1'b0;
            head_waddr  = '0;
         end else begin
            head_wvalid = link_rd_ff[ADDR_W];
            head_waddr  = link_rd_ff[ADDR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      want_ff <= want_in;
      idx_ff  <= idx_in;
      addr_ff <= addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int o = 0; o <= MAX_ORDER; o++) begin
            head_valid_ff[o] <= (o == MAX_ORDER);
            head_addr_ff[o]  <= '0;
         end
      end else if (head_we) begin
         head_valid_ff[idx_ff] <= head_wvalid;
         head_addr_ff[idx_ff]  <= head_waddr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.split) begin
         link_mem[slot_of(upper_addr)] <= {head_cur_valid, head_cur_addr};
      end
      if (cmd.pop) begin
         link_rd_ff <= link_mem[slot_of(head_cur_addr)];
      end
   end

   always_comb begin
      if (cmd.load_grant || cmd.load_refuse) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_grant) begin
         rsp_granted_ff <= 1'b1;
         rsp_addr_ff    <= AXW'(addr_ff);
         rsp_order_ff   <= OXW'(want_ff);
      end else if (cmd.load_refuse) begin
         rsp_granted_ff <= 1'b0;
         rsp_addr_ff    <= '0;
         rsp_order_ff   <= '0;
      end
   end

   assign status.oversize   = size_ext > (CMP_W'(1) << MAX_ORDER);
   assign status.head_valid = head_cur_valid;
   assign status.at_top     = (idx_ff == TOP_ORD);
   assign status.at_want    = (idx_ff == want_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_addr    = rsp_addr_ff[ADDR_OUT_W-1:0];
   assign rsp_order   = rsp_order_ff[ORDER_OUT_W-1:0];

endmodule

// ===== rtl/core/bba_controller.sv =====
// Controller state machine of the buddy block allocator.
// Depends on bba_pkg; drives the commands of bba_datapath.
module bba_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bba_pkg::bba_status_type status,
   output bba_pkg::bba_cmd_type    cmd
);
   import bba_pkg::*;

   bba_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SIZE;
            end
         end
         ST_SIZE: begin
            if (status.oversize) begin
               state_in = ST_REFUSE;
            end else begin
               cmd.init_scan = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.head_valid) begin
               cmd.pop  = 1'b1;
               state_in = ST_LINK;
            end else if (status.at_top) begin
               state_in = ST_REFUSE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_LINK: begin
            cmd.unlink = 1'b1;
            if (status.at_want) begin
               state_in = ST_GRANT;
            end else begin
               cmd.descend = 1'b1;
               state_in    = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            if (status.at_want) begin
               state_in = ST_GRANT;
            end
         end
         ST_GRANT: begin
            if (status.out_free) begin
               cmd.load_grant = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_REFUSE: begin
            if (status.out_free) begin
               cmd.load_refuse = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/buddy_block_allocator.sv =====
// Buddy block allocator top level. The wait from request acceptance to response valid grows
// for a grant with the orders from the wanted one up to that of the free block found, and
// for a refusal with the orders scanned; an oversize request is refused at its size check.
// A new request is taken in the cycle after the response is loaded; throughput is set by the
// serial list scan and the one-order-per-cycle split through the single-port link memory.
// Reset is synchronous: only the whole region is free; the link memory is not cleared.
module buddy_block_allocator #(
   parameter int unsigned MAX_ORDER = bba_pkg::MAX_ORDER_DEF,
   parameter int unsigned MIN_ORDER = bba_pkg::MIN_ORDER_DEF
) (
   input logic      clock,
   input logic      reset,
   bba_req_if.sink  req_ch,
   bba_rsp_if.source rsp_ch
);
   import bba_pkg::*;

   // The controller and datapath exchange only a command word and a status word.
   // The controller walks IDLE -> SIZE -> SCAN -> LINK -> SPLIT (skipped when no split is due) -> GRANT, or
   // diverts to REFUSE when the size exceeds the region or no list at or above
   // the wanted order holds a block.
   //
   // Splitting is folded: at each order below the popped one, only the upper
   // half ends up on that list, because the lower half is pushed and popped
   // again right away. The datapath therefore writes one link entry and one
   // list head per cycle, and the granted block is the lower half at the end.
   //
   // The whole region never has a successor on the top list, so popping it
   // clears the top head without reading the link memory. Every other pop
   // reads a link entry that was written when that block was pushed, which is
   // why the link memory needs no clearing pass after reset.
   //
   // The response register decouples the result from the consumer; a
   // finished request waits in GRANT or REFUSE only while that register is
   // still occupied and not being taken.

   bba_cmd_type    cmd;
   bba_status_type status;

   bba_controller u_bba_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bba_datapath #(
      .MAX_ORDER (MAX_ORDER),
      .MIN_ORDER (MIN_ORDER)
   ) u_bba_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_size    (req_ch.request_size),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_granted (rsp_ch.granted),
      .rsp_addr    (rsp_ch.block_address),
      .rsp_order   (rsp_ch.block_order)
   );

endmodule

// ===== rtl/core/bba_checker.sv =====
// Port-level assertion checker for the buddy block allocator, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator_defines.svh.
`include "buddy_block_allocator_defines.svh"

module bba_checker #(
   parameter int unsigned MAX_ORDER = bba_pkg::MAX_ORDER_DEF,
   parameter int unsigned MIN_ORDER = bba_pkg::MIN_ORDER_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_granted,
   input logic [bba_pkg::ADDR_OUT_W-1:0]      rsp_block_address,
   input logic [bba_pkg::ORDER_OUT_W-1:0]     rsp_block_order
);
   import bba_pkg::*;

   localparam int unsigned EFF_MIN = (MIN_ORDER < MAX_ORDER) ? MIN_ORDER : MAX_ORDER;
   localparam logic [ORDER_OUT_W-1:0] LOW_ORD = ORDER_OUT_W'(EFF_MIN);
   localparam logic [ORDER_OUT_W-1:0] TOP_ORD = ORDER_OUT_W'(MAX_ORDER);

   // A refused request reports no address and no order.
   `BBA_ASSERT_IMP(a_refuse_is_zero, clock, reset, rsp_valid && !rsp_granted,
      rsp_block_address == '0 && rsp_block_order == '0)

   // A granted block starts on a multiple of its own size.
   `BBA_ASSERT_IMP(a_grant_aligned, clock, reset, rsp_valid && rsp_granted,
      ((rsp_block_address >> rsp_block_order) << rsp_block_order) == rsp_block_address)

   // A granted block is never smaller than the minimum block nor larger than the region.
   `BBA_ASSERT_IMP(a_grant_order_range, clock, reset, rsp_valid && rsp_granted,
      rsp_block_order >= LOW_ORD && rsp_block_order <= TOP_ORD)

   // One request at a time: the block is busy right after taking a request.
   `BBA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // A stalled response keeps its contents.
   `BBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_granted) && $stable(rsp_block_address) && $stable(rsp_block_order))

endmodule

bind buddy_block_allocator bba_checker #(
   .MAX_ORDER (MAX_ORDER),
   .MIN_ORDER (MIN_ORDER)
) u_bba_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_granted       (rsp_ch.granted),
   .rsp_block_address (rsp_ch.block_address),
   .rsp_block_order   (rsp_ch.block_order)
);

// ===== tb/tb.sv =====
// Self-checking testbench of buddy_block_allocator: a scoreboard class keeps its own free
// lists, predicts the grant for every accepted request and checks each response in order.
// Depends on bba_pkg, the bba_req_if and bba_rsp_if interfaces, and the allocator top level.
module tb;
   import bba_pkg::*;

   localparam int unsigned TOP_ORDER  = MAX_ORDER_DEF;
   localparam int unsigned LOW_ORDER  = MIN_ORDER_DEF;
   // The smallest block the allocator ever hands out.
   localparam int unsigned EFF_MIN    = (LOW_ORDER < TOP_ORDER) ? LOW_ORDER : TOP_ORDER;
   localparam int unsigned LINK_DEPTH = 1 << (TOP_ORDER - EFF_MIN);
   localparam longint unsigned REGION_BYTES = 64'd1 << TOP_ORDER;
   localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
   localparam int unsigned RANDOM_REQUESTS = 1130;
   localparam int unsigned HOLD_OFF_CYCLES = 400;

   // One response as the block reports it.
   typedef struct packed {
      logic                   granted;
      logic [ADDR_OUT_W-1:0]  block_address;
      logic [ORDER_OUT_W-1:0] block_order;
   } grant_type;

   // Scoreboard: a private copy of the free lists and the link memory, plus the queue of
   // grants still owed by the block. A list head and a link are a valid bit over an address.
   class block_grant_tracker;
      logic [ADDR_OUT_W:0] list_head [TOP_ORDER+1];
      logic [ADDR_OUT_W:0] next_link [LINK_DEPTH];
      grant_type           expected_grants [$];
      int unsigned         mismatches;

      function new();
         foreach (list_head[k]) list_head[k] = '0;
         foreach (next_link[k]) next_link[k] = '0;
         // After reset the whole region is one free block at address zero.
         list_head[TOP_ORDER] = {1'b1, {ADDR_OUT_W{1'b0}}};
         mismatches = 0;
      endfunction

      function int unsigned link_slot(logic [ADDR_OUT_W-1:0] addr);
         return (int'(addr) >> EFF_MIN) & (LINK_DEPTH - 1);
      endfunction

      function void push_free(int unsigned lvl, logic [ADDR_OUT_W-1:0] addr);
         next_link[link_slot(addr)] = list_head[lvl];
         list_head[lvl] = {1'b1, addr};
      endfunction

      function logic [ADDR_OUT_W-1:0] pop_free(int unsigned lvl);
         logic [ADDR_OUT_W-1:0] addr;
         addr = list_head[lvl][ADDR_OUT_W-1:0];
         list_head[lvl] = next_link[link_slot(addr)];
         return addr;
      endfunction

      // Works out the grant for one accepted request and updates the free lists.
      function void note_request(logic [SIZE_W-1:0] size);
         int unsigned want;
         int unsigned lvl;
         logic [ADDR_OUT_W-1:0] base;
         grant_type outcome;
         outcome = '0;
         if (64'(size) <= REGION_BYTES) begin
            want = EFF_MIN;
            while (want < TOP_ORDER && (64'd1 << want) < 64'(size)) want++;
            lvl = want;
            while (lvl <= TOP_ORDER && !list_head[lvl][ADDR_OUT_W]) lvl++;
            if (lvl <= TOP_ORDER) begin
               // Halve down to the wanted order: upper half first, so the lower half
               // ends up on top of the list.
               while (lvl > want) begin
                  base = pop_free(lvl);
                  push_free(lvl - 1, base + (ADDR_OUT_W'(1) << (lvl - 1)));
                  push_free(lvl - 1, base);
                  lvl--;
               end
               outcome.granted       = 1'b1;
               outcome.block_address = pop_free(want);
               outcome.block_order   = ORDER_OUT_W'(want);
            end
         end
         expected_grants.push_back(outcome);
      endfunction

      function void check_grant(grant_type got);
         grant_type exp;
         if (expected_grants.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response: granted %0d address 'h%0h order %0d",
                     $time, got.granted, got.block_address, got.block_order);
            return;
         end
         exp = expected_grants.pop_front();
         if (got.granted !== exp.granted) begin
            mismatches++;
            $display("%0t: granted mismatch: expected %0d, actual %0d",
                     $time, exp.granted, got.granted);
         end
         if (got.block_address !== exp.block_address) begin
            mismatches++;
            $display("%0t: block_address mismatch: expected 'h%0h, actual 'h%0h",
                     $time, exp.block_address, got.block_address);
         end
         if (got.block_order !== exp.block_order) begin
            mismatches++;
            $display("%0t: block_order mismatch: expected %0d, actual %0d",
                     $time, exp.block_order, got.block_order);
         end
      endfunction

      function int unsigned outstanding();
         return expected_grants.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   bba_req_if req_bus ();
   bba_rsp_if rsp_bus ();

   buddy_block_allocator #(
      .MAX_ORDER(TOP_ORDER),
      .MIN_ORDER(LOW_ORDER)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   always #2 clock = ~clock;

   block_grant_tracker tracker;

   // Set by the request side to ask for stretches without idling on both sides, and to
   // ask the response side for one long hold-off.
   bit steady;
   bit hold_off_pending;
   int unsigned stall_left;

   // Idle lengths: mostly a few cycles, now and then a long one.
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Request sizes are weighted toward small blocks so that the region lasts most of the
   // run before it is used up; oversize and power-of-two boundary sizes are mixed in.
   function automatic logic [SIZE_W-1:0] choose_size();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 75) return SIZE_W'($urandom_range(0, 64));
      if (sel < 92) return SIZE_W'($urandom_range(65, 1024));
      if (sel < 97) return SIZE_W'($urandom_range(1025, 8192));
      if (sel < 98) return SIZE_W'($urandom_range(8193, 65536));
      if (sel < 99) return SIZE_W'($urandom_range(REGION_BYTES + 1, SIZE_MAX));
      return SIZE_W'((1 << $urandom_range(EFF_MIN, 12)) + $urandom_range(0, 2) - 1);
   endfunction

   // Offers one request after an optional idle gap and returns once it is accepted.
   // Valid stays high afterward so that back-to-back requests need no extra cycle.
   task automatic send_request(logic [SIZE_W-1:0] size, int unsigned gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         req_bus.request_size <= SIZE_W'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.request_size <= size;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      tracker.note_request(size);
   endtask

   // Stops offering requests until every predicted response has come back.
   task automatic drain_outstanding();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // Response side: checks every accepted response and throttles ready. A hold-off asked
   // by the request side keeps ready low for a long stretch so that the allocator fills
   // up and stalls its request input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            tracker.check_grant({rsp_bus.granted, rsp_bus.block_address,
                                 rsp_bus.block_order});
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (steady || $urandom_range(0, 4) != 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            stall_left = pick_gap() - 1;
            rsp_bus.ready <= 1'b0;
         end
      end
   end

   initial begin
      logic [SIZE_W-1:0] directed_sizes [$];
      int unsigned n;
      tracker = new();
      steady = 1'b0;
      hold_off_pending = 1'b0;
      stall_left = 0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.request_size <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: zero size, sizes around the minimum block, an allocation that
      // splits the whole region, a full-region request once the top list is empty,
      // oversize requests up to the widest size, and a few block boundaries.
      directed_sizes = '{
         SIZE_W'(0), SIZE_W'(1), SIZE_W'(15), SIZE_W'(16), SIZE_W'(17), SIZE_W'(32),
         SIZE_W'(33), SIZE_W'(REGION_BYTES), SIZE_W'(REGION_BYTES - 1),
         SIZE_W'(REGION_BYTES + 1), SIZE_MAX, SIZE_W'(100), SIZE_W'(1023),
         SIZE_W'(1024), SIZE_W'(1025), SIZE_W'(4096), SIZE_W'(65536), SIZE_W'(65537),
         SIZE_W'(0)
      };
      foreach (directed_sizes[k]) begin
         send_request(directed_sizes[k], $urandom_range(0, 1) ? 0 : pick_gap());
      end
      // Let the block go fully idle once before the random part.
      drain_outstanding();

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         // Every fourth window of 120 requests runs with no idling on either side.
         steady = ((n / 120) % 4 == 2);
         // One long response hold-off while requests keep coming back to back.
         if (n == 400) hold_off_pending = 1'b1;
         if (n % 250 == 249 || $urandom_range(0, 99) == 0) drain_outstanding();
         if (steady || (n >= 400 && n < 420) || $urandom_range(0, 1) == 0) begin
            send_request(choose_size(), 0);
         end else begin
            send_request(choose_size(), pick_gap());
         end
      end
      steady = 1'b0;

      drain_outstanding();
      // Extra cycles to catch a stray response after the last expected one.
      repeat (60) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2400000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
